FILE: src/rgb_to_yuv420_converter_top_macros.svh
// Assertion helpers shared by the converter RTL.
`ifndef RGB_TO_YUV420_CONVERTER_TOP_MACROS_SVH
`define RGB_TO_YUV420_CONVERTER_TOP_MACROS_SVH

// Checked on every rising edge of clk once reset is released.
`define RGB2YUV_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define RGB2YUV_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/rgb2yuv_pkg.sv
package rgb2yuv_pkg;

    localparam int DEF_MAX_DIMENSION = 4096;

    localparam int PIX_W      = 8;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int SUM_W      = 19;

    localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RESET  = 13'd1920;
    localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RESET = 13'd1080;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic signed [8:0] coef_t;

    localparam coef_t Y_R =  9'sd66;
    localparam coef_t Y_G =  9'sd129;
    localparam coef_t Y_B =  9'sd25;
    localparam coef_t U_R = -9'sd38;
    localparam coef_t U_G = -9'sd74;
    localparam coef_t U_B =  9'sd112;
    localparam coef_t V_R =  9'sd112;
    localparam coef_t V_G = -9'sd94;
    localparam coef_t V_B = -9'sd18;

    localparam logic signed [SUM_W-1:0] ROUND_BIAS = 19'sd128;
    localparam logic [PIX_W-1:0] LUMA_OFFSET   = 8'd16;
    localparam logic [PIX_W-1:0] CHROMA_OFFSET = 8'd128;

    // Weighted sum of the three components plus rounding bias.
    function automatic logic signed [SUM_W-1:0] dot3(
        input logic [PIX_W-1:0] r,
        input logic [PIX_W-1:0] g,
        input logic [PIX_W-1:0] b,
        input coef_t            cr,
        input coef_t            cg,
        input coef_t            cb
    );
        logic signed [SUM_W-1:0] pr;
        logic signed [SUM_W-1:0] pg;
        logic signed [SUM_W-1:0] pb;
        pr = $signed({{(SUM_W-PIX_W){1'b0}}, r}) * SUM_W'(cr);
        pg = $signed({{(SUM_W-PIX_W){1'b0}}, g}) * SUM_W'(cg);
        pb = $signed({{(SUM_W-PIX_W){1'b0}}, b}) * SUM_W'(cb);
        return pr + pg + pb + ROUND_BIAS;
    endfunction

    // Low byte of the floored shift by 8, then the offset, wrapping modulo 256.
    function automatic logic [PIX_W-1:0] shift_offset(
        input logic signed [SUM_W-1:0] sum,
        input logic [PIX_W-1:0]        offset
    );
        return sum[15:8] + offset;
    endfunction

endpackage

FILE: src/rgb2yuv_pix_if.sv
interface rgb2yuv_pix_if
    import rgb2yuv_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

FILE: src/rgb2yuv_res_if.sv
interface rgb2yuv_res_if
    import rgb2yuv_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] luma;
    logic             chroma_valid;
    logic             chroma_is_v;
    logic [PIX_W-1:0] chroma_sample;
    logic             frame_last;

    modport source (
        output valid, output luma, output chroma_valid, output chroma_is_v,
        output chroma_sample, output frame_last, input ready
    );
    modport sink (
        input valid, input luma, input chroma_valid, input chroma_is_v,
        input chroma_sample, input frame_last, output ready
    );
endinterface

FILE: src/rgb_to_yuv420_converter_top.sv
// RGB to YUV 4:2:0 converter, BT.601 integer coefficients.
// pix: one RGB pixel per beat, raster order, valid/ready handshake.
// res: one beat per pixel carrying luma, and on even columns a chroma
//      sample (U on even rows, V on odd rows); frame_last marks the final
//      pixel of the frame as set by frame_width and frame_height.
// Configuration: write_en/write_index/write_data, taken on any edge with
//      write_en high; write only while no pixel is in flight.
// An accepted pixel passes the input register, then the result register, to res.
// Throughput: one pixel per cycle while res.ready holds, set by the
//      two-stage pipeline (input register, result register), no shared unit.
// pix.ready stays high as long as the result register drains or the
//      input register is free, so a waiting result does not block intake
//      of one more pixel.
// Receiver stall: the result register holds its beat, the input register
//      fills, and then pix.ready drops until res.ready returns.
// Reset: clears the pipeline, the column and row counters and loads
//      frame_width 1920 and frame_height 1080.
`include "rgb_to_yuv420_converter_top_macros.svh"

module rgb_to_yuv420_converter_top
    import rgb2yuv_pkg::*;
#(
    parameter int MAX_DIMENSION = DEF_MAX_DIMENSION
) (
    input  logic                  clk,
    input  logic                  rst_n,
    rgb2yuv_pix_if.sink           pix,
    rgb2yuv_res_if.source         res,
    input  logic                  write_en,
    input  logic [CFG_IDX_W-1:0]  write_index,
    input  logic [CFG_DATA_W-1:0] write_data
);

    localparam int CNT_W = (MAX_DIMENSION > 2) ? $clog2(MAX_DIMENSION) : 1;
    localparam int DIM_W = CNT_W + 1;

    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic [CNT_W-1:0]      col_reg;
    logic [CNT_W-1:0]      col_next;
    logic [CNT_W-1:0]      row_reg;
    logic [CNT_W-1:0]      row_next;

    logic [DIM_W-1:0] width_eff;
    logic [DIM_W-1:0] height_eff;
    logic [DIM_W-1:0] col_plus;
    logic [DIM_W-1:0] row_plus;
    logic             last_col;
    logic             last_row;

    logic             accept;
    logic             s1_adv;
    logic             out_adv;

    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_red_reg;
    logic [PIX_W-1:0] s1_green_reg;
    logic [PIX_W-1:0] s1_blue_reg;
    logic             s1_col_even_reg;
    logic             s1_row_odd_reg;
    logic             s1_last_reg;

    logic [PIX_W-1:0] luma_next;
    logic [PIX_W-1:0] chroma_next;
    logic [PIX_W-1:0] u_val;
    logic [PIX_W-1:0] v_val;

    logic             out_valid_reg;
    logic [PIX_W-1:0] luma_reg;
    logic             chroma_valid_reg;
    logic             chroma_is_v_reg;
    logic [PIX_W-1:0] chroma_sample_reg;
    logic             frame_last_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= FRAME_WIDTH_RESET;
            height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (write_en)
        begin
            unique case (cfg_reg_t'(write_index))
                CFG_FRAME_WIDTH:  width_reg  <= write_data;
                CFG_FRAME_HEIGHT: height_reg <= write_data;
                default: ;
            endcase
        end
    end

    // Zero acts as one, oversize saturates
    always_comb
    begin
        priority if (32'(width_reg) > 32'(MAX_DIMENSION))
            width_eff = DIM_W'(MAX_DIMENSION);
        else if (width_reg == '0)
            width_eff = DIM_W'(1);
        else
            width_eff = DIM_W'(width_reg);

        priority if (32'(height_reg) > 32'(MAX_DIMENSION))
            height_eff = DIM_W'(MAX_DIMENSION);
        else if (height_reg == '0)
            height_eff = DIM_W'(1);
        else
            height_eff = DIM_W'(height_reg);
    end

    // Raster position; wrap when at or past the last position
    always_comb
    begin
        col_plus = {1'b0, col_reg} + DIM_W'(1);
        row_plus = {1'b0, row_reg} + DIM_W'(1);
        last_col = (col_plus >= width_eff);
        last_row = (row_plus >= height_eff);
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_plus[CNT_W-1:0];
        end
        else
        begin
            col_next = col_plus[CNT_W-1:0];
            row_next = row_reg;
        end
    end

    // Handshake
    assign out_adv   = !out_valid_reg || res.ready;
    assign s1_adv    = !s1_valid_reg || out_adv;
    assign accept    = pix.valid && s1_adv;
    assign pix.ready = s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (s1_adv)
                s1_valid_reg <= pix.valid;
            if (out_adv)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_red_reg      <= pix.red;
            s1_green_reg    <= pix.green;
            s1_blue_reg     <= pix.blue;
            s1_col_even_reg <= !col_reg[0];
            s1_row_odd_reg  <= row_reg[0];
            s1_last_reg     <= last_col && last_row;
        end
    end

    // Color arithmetic
    always_comb
    begin
        luma_next = shift_offset(
            dot3(s1_red_reg, s1_green_reg, s1_blue_reg, Y_R, Y_G, Y_B), LUMA_OFFSET);
        u_val = shift_offset(
            dot3(s1_red_reg, s1_green_reg, s1_blue_reg, U_R, U_G, U_B), CHROMA_OFFSET);
        v_val = shift_offset(
            dot3(s1_red_reg, s1_green_reg, s1_blue_reg, V_R, V_G, V_B), CHROMA_OFFSET);
        if (!s1_col_even_reg)
            chroma_next = '0;
        else if (s1_row_odd_reg)
            chroma_next = v_val;
        else
            chroma_next = u_val;
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (out_adv && s1_valid_reg)
        begin
            luma_reg          <= luma_next;
            chroma_valid_reg  <= s1_col_even_reg;
            chroma_is_v_reg   <= s1_col_even_reg && s1_row_odd_reg;
            chroma_sample_reg <= chroma_next;
            frame_last_reg    <= s1_last_reg;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.luma          = luma_reg;
    assign res.chroma_valid  = chroma_valid_reg;
    assign res.chroma_is_v   = chroma_is_v_reg;
    assign res.chroma_sample = chroma_sample_reg;
    assign res.frame_last    = frame_last_reg;

    `RGB2YUV_ASSERT(a_no_chroma_zero, (out_valid_reg && !chroma_valid_reg) |-> (!chroma_is_v_reg && chroma_sample_reg == '0), "chroma fields set on a pixel without chroma")
    `RGB2YUV_ASSERT(a_accept_fills_s1, accept |=> s1_valid_reg, "accepted beat lost before the input register")
    `RGB2YUV_ASSERT(a_out_from_s1, (out_valid_reg && !$past(out_valid_reg)) |-> $past(s1_valid_reg), "result beat appeared without a pixel in the input register")
    `RGB2YUV_ASSERT(a_frame_wrap, (accept && last_col && last_row) |=> (col_reg == '0 && row_reg == '0), "counters did not wrap after the last pixel of a frame")
    `RGB2YUV_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!out_valid_reg && !s1_valid_reg), "pipeline holds a beat during reset")

endmodule
